### src/ios_pkg.sv
// Package for the interval overlap search block.
// Holds the sequencer state type, the change kind codes and the fixed field widths.
// Depends on nothing; imported by interval_overlap_search.
package ios_pkg;

   // Default sizing of the region table and of the coordinates.
   localparam int TABLE_DEPTH_DEF = 64;
   localparam int COORD_BITS_DEF  = 32;

   // Fixed field widths.
   localparam int CHROM_BITS  = 5;
   localparam int LABEL_BITS  = 16;
   localparam int COPIES_BITS = 4;
   localparam int PCT_BITS    = 14;
   localparam int STEP_BITS   = $clog2(PCT_BITS);
   localparam int FIELD_BITS  = 32;

   // Full scale of the ratio (100 percent in hundredths) and the cutoff after reset.
   localparam logic [PCT_BITS-1:0] FULL_SCALE   = 14'd10000;
   localparam logic [PCT_BITS-1:0] CUTOFF_RESET = 14'd5000;

   // Operation codes of a request beat.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Copy-number change reported with a match.
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_LOSS = 2'd1,
      KIND_GAIN = 2'd2
   } kind_type;

   // Query sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_DIFF,
      ST_ABS,
      ST_MUL_OV,
      ST_MUL_UN,
      ST_CMP,
      ST_DIV,
      ST_EMIT,
      ST_NEXT,
      ST_FINISH
   } state_type;

   // Copy numbers zero and one are a loss, three and four a gain.
   function automatic kind_type kind_of(input logic [COPIES_BITS-1:0] copies);
      kind_type kind;
      unique case (copies)
         4'd0, 4'd1: kind = KIND_LOSS;
         4'd3, 4'd4: kind = KIND_GAIN;
         default:    kind = KIND_NONE;
      endcase
      return kind;
   endfunction

endpackage

### src/interval_overlap_search.sv
// Top level of the interval overlap search block: region table, query sequencer,
// shared multiplier and bit-serial divider. Depends on ios_pkg.
//
// The block keeps a table of up to TABLE_DEPTH reference regions. A load beat appends
// one region (loads into a full table are dropped). A query beat holds req_stall high
// while the sequencer walks the table in load order, one entry at a time through a
// single registered memory read port. Each entry passes ST_READ and ST_EVAL; an entry on
// another chromosome then goes to ST_NEXT, a same-chromosome entry passes ST_DIFF and
// ST_ABS and, if it can still match, ST_MUL_OV, ST_MUL_UN and ST_CMP. A match then runs
// the one-bit-per-cycle divider in ST_DIV to form the rounded percentage (skipped when the
// ratio saturates at 100 percent) and leaves through ST_EMIT. Both products of the cutoff
// test go through one shared multiplier in ST_MUL_OV and ST_MUL_UN. Matches leave in load
// order; each is held back one step so that the final one can carry rsp_last, and a query
// with no match gives one beat with rsp_matched low. No clearing pass is needed after
// reset.
module interval_overlap_search
   import ios_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // Request channel.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_operation,
   input  logic [CHROM_BITS-1:0]  req_chrom_code,
   input  logic [FIELD_BITS-1:0]  req_interval_begin,
   input  logic [FIELD_BITS-1:0]  req_interval_end,
   input  logic [LABEL_BITS-1:0]  req_region_label,
   input  logic [COPIES_BITS-1:0] req_copies,
   // Response channel.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_matched,
   output logic [LABEL_BITS-1:0]  rsp_match_label,
   output logic [PCT_BITS-1:0]    rsp_percent_hundredths,
   output logic [1:0]             rsp_change_kind,
   output logic                   rsp_last,
   // Cutoff register write port.
   input  logic                   csr_wr_en,
   input  logic [PCT_BITS-1:0]    csr_wr_data
);

   localparam int CNT_BITS = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int PROD_W   = COORD_BITS + PCT_BITS;
   localparam int DIV_W    = COORD_BITS + PCT_BITS + 2;

   // Region table.
   logic [COORD_BITS-1:0]  begin_mem  [TABLE_DEPTH];
   logic [COORD_BITS-1:0]  end_mem    [TABLE_DEPTH];
   logic [CHROM_BITS-1:0]  chrom_mem  [TABLE_DEPTH];
   logic [LABEL_BITS-1:0]  label_mem  [TABLE_DEPTH];
   logic [COPIES_BITS-1:0] copies_mem [TABLE_DEPTH];

   // Registered table read.
   logic [COORD_BITS-1:0]  rd_begin_ff;
   logic [COORD_BITS-1:0]  rd_end_ff;
   logic [CHROM_BITS-1:0]  rd_chrom_ff;
   logic [LABEL_BITS-1:0]  rd_label_ff;
   logic [COPIES_BITS-1:0] rd_copies_ff;

   state_type state_ff, state_in;

   logic [PCT_BITS-1:0]    cutoff_ff, cutoff_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   logic [CHROM_BITS-1:0]  q_chrom_ff, q_chrom_in;
   logic [COORD_BITS-1:0]  q_begin_ff, q_begin_in;
   logic [COORD_BITS-1:0]  q_end_ff, q_end_in;

   // Interval bounds: overlap runs from ov_lo to ov_hi, union from un_lo to un_hi.
   logic [COORD_BITS-1:0]  ov_hi_ff, ov_hi_in;
   logic [COORD_BITS-1:0]  ov_lo_ff, ov_lo_in;
   logic [COORD_BITS-1:0]  un_hi_ff, un_hi_in;
   logic [COORD_BITS-1:0]  un_lo_ff, un_lo_in;
   logic signed [COORD_BITS:0] ov_ff, ov_in;
   logic signed [COORD_BITS:0] un_ff, un_in;
   logic [COORD_BITS-1:0]  aov_ff, aov_in;
   logic [COORD_BITS-1:0]  aun_ff, aun_in;

   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [PROD_W-1:0]      cross_ff, cross_in;
   logic [DIV_W-1:0]       rem_ff, rem_in;
   logic [DIV_W-1:0]       dsh_ff, dsh_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [PCT_BITS-1:0]    pct_ff, pct_in;

   // Match held back until it is known whether it is the final one.
   logic                   pend_valid_ff, pend_valid_in;
   logic [LABEL_BITS-1:0]  pend_label_ff, pend_label_in;
   logic [PCT_BITS-1:0]    pend_pct_ff, pend_pct_in;
   kind_type               pend_kind_ff, pend_kind_in;

   // Response output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_matched_ff, rsp_matched_in;
   logic [LABEL_BITS-1:0]  rsp_label_ff, rsp_label_in;
   logic [PCT_BITS-1:0]    rsp_pct_ff, rsp_pct_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   req_accept;
   logic                   rsp_free;
   logic                   mem_write;
   logic [COORD_BITS-1:0]  load_begin;
   logic [COORD_BITS-1:0]  load_end;
   logic [COORD_BITS-1:0]  mul_a;
   logic [PCT_BITS-1:0]    mul_b;
   logic [PROD_W-1:0]      mul_res;
   logic signed [COORD_BITS:0] ov_neg;
   logic signed [COORD_BITS:0] un_neg;
   logic [DIV_W:0]         div_sub;
   logic                   div_bit;
   logic [CNT_BITS-1:0]    idx_inc;

   // Handshake conditions.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign mem_write  = req_accept && (req_operation == OP_LOAD)
                       && (count_ff < CNT_BITS'(TABLE_DEPTH));
   assign load_begin = COORD_BITS'(req_interval_begin);
   assign load_end   = COORD_BITS'(req_interval_end);

   // Shared multiplier: overlap times full scale, then union times cutoff.
   assign mul_a   = (state_ff == ST_MUL_OV) ? aov_ff : aun_ff;
   assign mul_b   = (state_ff == ST_MUL_OV) ? FULL_SCALE : cutoff_ff;
   assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Magnitudes of negative differences and one divider step.
   assign ov_neg  = -ov_ff;
   assign un_neg  = -un_ff;
   assign div_sub = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign div_bit = !div_sub[DIV_W];
   assign idx_inc = idx_ff + 1'b1;

   // Table write port and registered read port.
   always_ff @(posedge clock) begin
      if (mem_write) begin
         begin_mem[count_ff[IDX_BITS-1:0]]  <= load_begin;
         end_mem[count_ff[IDX_BITS-1:0]]    <= load_end;
         chrom_mem[count_ff[IDX_BITS-1:0]]  <= req_chrom_code;
         label_mem[count_ff[IDX_BITS-1:0]]  <= req_region_label;
         copies_mem[count_ff[IDX_BITS-1:0]] <= req_copies;
      end
      if (state_ff == ST_READ) begin
         rd_begin_ff  <= begin_mem[idx_ff[IDX_BITS-1:0]];
         rd_end_ff    <= end_mem[idx_ff[IDX_BITS-1:0]];
         rd_chrom_ff  <= chrom_mem[idx_ff[IDX_BITS-1:0]];
         rd_label_ff  <= label_mem[idx_ff[IDX_BITS-1:0]];
         rd_copies_ff <= copies_mem[idx_ff[IDX_BITS-1:0]];
      end
   end

   // Sequencer next state and datapath next values.
   always_comb begin
      state_in       = state_ff;
      cutoff_in      = csr_wr_en ? csr_wr_data : cutoff_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      q_chrom_in     = q_chrom_ff;
      q_begin_in     = q_begin_ff;
      q_end_in       = q_end_ff;
      ov_hi_in       = ov_hi_ff;
      ov_lo_in       = ov_lo_ff;
      un_hi_in       = un_hi_ff;
      un_lo_in       = un_lo_ff;
      ov_in          = ov_ff;
      un_in          = un_ff;
      aov_in         = aov_ff;
      aun_in         = aun_ff;
      prod_in        = prod_ff;
      cross_in       = cross_ff;
      rem_in         = rem_ff;
      dsh_in         = dsh_ff;
      step_in        = step_ff;
      pct_in         = pct_ff;
      pend_valid_in  = pend_valid_ff;
      pend_label_in  = pend_label_ff;
      pend_pct_in    = pend_pct_ff;
      pend_kind_in   = pend_kind_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_matched_in = rsp_matched_ff;
      rsp_label_in   = rsp_label_ff;
      rsp_pct_in     = rsp_pct_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (mem_write) begin
               count_in = count_ff + 1'b1;
            end
            if (req_accept && (req_operation == OP_QUERY)) begin
               q_chrom_in    = req_chrom_code;
               q_begin_in    = load_begin;
               q_end_in      = load_end;
               idx_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = (count_ff == '0) ? ST_FINISH : ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            // Skip other chromosomes; else pick the bounds of overlap and union.
            ov_hi_in = (q_end_ff < rd_end_ff) ? q_end_ff : rd_end_ff;
            un_hi_in = (q_end_ff < rd_end_ff) ? rd_end_ff : q_end_ff;
            ov_lo_in = (q_begin_ff > rd_begin_ff) ? q_begin_ff : rd_begin_ff;
            un_lo_in = (q_begin_ff > rd_begin_ff) ? rd_begin_ff : q_begin_ff;
            state_in = (rd_chrom_ff == q_chrom_ff) ? ST_DIFF : ST_NEXT;
         end
         ST_DIFF: begin
            ov_in    = $signed({1'b0, ov_hi_ff}) - $signed({1'b0, ov_lo_ff});
            un_in    = $signed({1'b0, un_hi_ff}) - $signed({1'b0, un_lo_ff});
            state_in = ST_ABS;
         end
         ST_ABS: begin
            // Overlap and union must share a sign; a zero union never matches.
            aov_in   = ov_ff[COORD_BITS-1:0];
            aun_in   = un_ff[COORD_BITS-1:0];
            state_in = ST_NEXT;
            if (un_ff != '0) begin
               if (!un_ff[COORD_BITS]) begin
                  if (!ov_ff[COORD_BITS] && (ov_ff != '0)) begin
                     state_in = ST_MUL_OV;
                  end
               end else if (ov_ff[COORD_BITS]) begin
                  aov_in   = ov_neg[COORD_BITS-1:0];
                  aun_in   = un_neg[COORD_BITS-1:0];
                  state_in = ST_MUL_OV;
               end
            end
         end
         ST_MUL_OV: begin
            prod_in  = mul_res;
            state_in = ST_MUL_UN;
         end
         ST_MUL_UN: begin
            cross_in = mul_res;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Exact cutoff test; a ratio of one or more saturates without dividing.
            rem_in  = DIV_W'({prod_ff, 1'b0}) + DIV_W'(aun_ff);
            dsh_in  = DIV_W'(aun_ff) << PCT_BITS;
            step_in = STEP_BITS'(PCT_BITS - 1);
            pct_in  = '0;
            if (prod_ff > cross_ff) begin
               if (aov_ff >= aun_ff) begin
                  pct_in   = FULL_SCALE;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_DIV;
               end
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DIV: begin
            // Restoring division of (2*overlap*scale + union) by 2*union.
            if (div_bit) begin
               rem_in = div_sub[DIV_W-1:0];
            end
            pct_in  = {pct_ff[PCT_BITS-2:0], div_bit};
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Release the held match as a non-final beat, then hold the new one.
            if (!pend_valid_ff || rsp_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in   = 1'b1;
                  rsp_matched_in = 1'b1;
                  rsp_label_in   = pend_label_ff;
                  rsp_pct_in     = pend_pct_ff;
                  rsp_kind_in    = pend_kind_ff;
                  rsp_last_in    = 1'b0;
               end
               pend_valid_in = 1'b1;
               pend_label_in = rd_label_ff;
               pend_pct_in   = pct_ff;
               pend_kind_in  = kind_of(rd_copies_ff);
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            idx_in   = idx_inc;
            state_in = (idx_inc == count_ff) ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            // Final beat: the held match, or a no-match beat.
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_last_in    = 1'b1;
               rsp_matched_in = pend_valid_ff;
               rsp_label_in   = pend_valid_ff ? pend_label_ff : '0;
               rsp_pct_in     = pend_valid_ff ? pend_pct_ff : '0;
               rsp_kind_in    = pend_valid_ff ? pend_kind_ff : KIND_NONE;
               pend_valid_in  = 1'b0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cutoff_ff     <= CUTOFF_RESET;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cutoff_ff     <= cutoff_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      q_chrom_ff     <= q_chrom_in;
      q_begin_ff     <= q_begin_in;
      q_end_ff       <= q_end_in;
      ov_hi_ff       <= ov_hi_in;
      ov_lo_ff       <= ov_lo_in;
      un_hi_ff       <= un_hi_in;
      un_lo_ff       <= un_lo_in;
      ov_ff          <= ov_in;
      un_ff          <= un_in;
      aov_ff         <= aov_in;
      aun_ff         <= aun_in;
      prod_ff        <= prod_in;
      cross_ff       <= cross_in;
      rem_ff         <= rem_in;
      dsh_ff         <= dsh_in;
      step_ff        <= step_in;
      pct_ff         <= pct_in;
      pend_label_ff  <= pend_label_in;
      pend_pct_ff    <= pend_pct_in;
      pend_kind_ff   <= pend_kind_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_label_ff   <= rsp_label_in;
      rsp_pct_ff     <= rsp_pct_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // Response ports.
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_matched            = rsp_matched_ff;
   assign rsp_match_label        = rsp_label_ff;
   assign rsp_percent_hundredths = rsp_pct_ff;
   assign rsp_change_kind        = rsp_kind_ff;
   assign rsp_last               = rsp_last_ff;

`ifndef SYNTH
   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(TABLE_DEPTH))
      else $error("region count exceeds table depth");

   // No match is left behind once the sequencer is back at rest.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("held match left over after query");

   // The divider never produces a percentage beyond full scale.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (pct_ff <= FULL_SCALE))
      else $error("percentage above full scale");

   // A no-match beat is always the final beat of its query.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_matched) |-> rsp_last)
      else $error("no-match beat without last");

   // Finishing a query puts a final beat on the response port.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_free) |=> (rsp_valid && rsp_last))
      else $error("query finished without a final beat");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for interval_overlap_search: region loads, overlap queries, cutoff.
// A region_matcher class mirrors the region table and predicts every result beat.
// Depends on ios_pkg and the interval_overlap_search RTL.

// One request beat as the driver presents it.
typedef struct packed {
   logic        op;
   logic [4:0]  chrom;
   logic [31:0] from_pos;
   logic [31:0] to_pos;
   logic [15:0] label;
   logic [3:0]  copies;
} region_req_type;

// One result beat, predicted or observed.
typedef struct packed {
   logic               matched;
   logic [15:0]        label;
   logic [13:0]        pct;
   ios_pkg::kind_type  kind;
   logic               last;
} match_beat_type;

// Keeps a shadow of the region table and the cutoff, and the queue of result
// beats that accepted queries still owe.
class region_matcher;
   logic [4:0]  stored_chrom  [ios_pkg::TABLE_DEPTH_DEF];
   logic [31:0] stored_begin  [ios_pkg::TABLE_DEPTH_DEF];
   logic [31:0] stored_end    [ios_pkg::TABLE_DEPTH_DEF];
   logic [15:0] stored_label  [ios_pkg::TABLE_DEPTH_DEF];
   logic [3:0]  stored_copies [ios_pkg::TABLE_DEPTH_DEF];
   int loaded;
   int loads_dropped;
   int queries;
   int beats_checked;
   int hits_seen;
   int errors;
   longint unsigned cutoff;
   match_beat_type due_matches[$];

   function new();
      loaded        = 0;
      loads_dropped = 0;
      queries       = 0;
      beats_checked = 0;
      hits_seen     = 0;
      errors        = 0;
      cutoff        = 64'(ios_pkg::CUTOFF_RESET);
   endfunction

   // Note an accepted request beat; a query adds the beats it must produce.
   function void take_request(region_req_type item);
      longint qb, qe, rb, re, ov, un;
      longint unsigned aov, aun, pct;
      match_beat_type found[$];
      match_beat_type beat;
      int i;
      if (item.op == ios_pkg::OP_LOAD) begin
         if (loaded < ios_pkg::TABLE_DEPTH_DEF) begin
            stored_chrom[loaded]  = item.chrom;
            stored_begin[loaded]  = item.from_pos;
            stored_end[loaded]    = item.to_pos;
            stored_label[loaded]  = item.label;
            stored_copies[loaded] = item.copies;
            loaded++;
         end else begin
            loads_dropped++;
         end
         return;
      end
      queries++;
      qb = longint'(item.from_pos);
      qe = longint'(item.to_pos);
      for (i = 0; i < loaded; i++) begin
         if (stored_chrom[i] != item.chrom) continue;
         rb = longint'(stored_begin[i]);
         re = longint'(stored_end[i]);
         ov = ((qe < re) ? qe : re) - ((qb > rb) ? qb : rb);
         un = ((qe > re) ? qe : re) - ((qb < rb) ? qb : rb);
         // A zero union never matches; a negative union needs a negative overlap.
         if (un == 0) continue;
         if (un > 0) begin
            if (ov <= 0) continue;
            aov = ov;
            aun = un;
         end else begin
            if (ov >= 0) continue;
            aov = -ov;
            aun = -un;
         end
         if (!(aov * 10000 > cutoff * aun)) continue;
         pct = (2 * aov * 10000 + aun) / (2 * aun);
         if (pct > 10000) pct = 10000;
         beat.matched = 1'b1;
         beat.label   = stored_label[i];
         beat.pct     = pct[13:0];
         case (stored_copies[i])
            4'd0, 4'd1: beat.kind = ios_pkg::KIND_LOSS;
            4'd3, 4'd4: beat.kind = ios_pkg::KIND_GAIN;
            default:    beat.kind = ios_pkg::KIND_NONE;
         endcase
         beat.last = 1'b0;
         found.insert(found.size(), beat);
      end
      if (found.size() == 0) begin
         beat.matched = 1'b0;
         beat.label   = '0;
         beat.pct     = '0;
         beat.kind    = ios_pkg::KIND_NONE;
         beat.last    = 1'b1;
         found.insert(found.size(), beat);
      end
      found[found.size()-1].last = 1'b1;
      foreach (found[k]) due_matches.insert(due_matches.size(), found[k]);
   endfunction

   // Compare an accepted result beat with the oldest outstanding prediction.
   function void check_beat(match_beat_type got);
      match_beat_type want;
      beats_checked++;
      if (got.matched === 1'b1) hits_seen++;
      if (due_matches.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("tb_top: result beat with nothing outstanding: matched %0b label %h",
                     got.matched, got.label);
         return;
      end
      want = due_matches.pop_front();
      if (got.matched !== want.matched || got.label !== want.label ||
          got.pct !== want.pct || got.kind !== want.kind || got.last !== want.last) begin
         errors++;
         if (errors <= 10) begin
            $write("tb_top: mismatch: expected matched %0b label %h pct %0d kind %0d last %0b,",
                   want.matched, want.label, want.pct, want.kind, want.last);
            $display(" got matched %0b label %h pct %0d kind %0d last %0b",
                     got.matched, got.label, got.pct, got.kind, got.last);
         end
      end
   endfunction
endclass

module tb_top;
   import ios_pkg::*;

   // Longest stretch with no beat moving on either channel: a full table of
   // failing same-chromosome entries plus both sides' longest waits, with margin.
   localparam int WATCHDOG_LIMIT  = 4000;
   // Cycles allowed after the last result before the block counts as idle.
   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 23;
   localparam logic [13:0] CUT_TOP = 14'h3FFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_operation = OP_LOAD;
   logic [CHROM_BITS-1:0]  req_chrom_code = '0;
   logic [FIELD_BITS-1:0]  req_interval_begin = '0;
   logic [FIELD_BITS-1:0]  req_interval_end = '0;
   logic [LABEL_BITS-1:0]  req_region_label = '0;
   logic [COPIES_BITS-1:0] req_copies = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_matched;
   logic [LABEL_BITS-1:0]  rsp_match_label;
   logic [PCT_BITS-1:0]    rsp_percent_hundredths;
   logic [1:0]             rsp_change_kind;
   logic                   rsp_last;
   logic                   csr_wr_en = 1'b0;
   logic [PCT_BITS-1:0]    csr_wr_data = '0;

   region_matcher  matcher;
   bit             quiet_mode = 1'b0;
   int             rsp_wait = 0;
   int             quiet_cycles = 0;
   match_beat_type seen_beat;

   interval_overlap_search DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_operation          (req_operation),
      .req_chrom_code         (req_chrom_code),
      .req_interval_begin     (req_interval_begin),
      .req_interval_end       (req_interval_end),
      .req_region_label       (req_region_label),
      .req_copies             (req_copies),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_matched            (rsp_matched),
      .rsp_match_label        (rsp_match_label),
      .rsp_percent_hundredths (rsp_percent_hundredths),
      .rsp_change_kind        (rsp_change_kind),
      .rsp_last               (rsp_last),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data)
   );

   // Free-running clock, period 2.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Idle cycles before the next beat; none at all in quiet phases.
   function automatic int draw_wait();
      if (quiet_mode) return 0;
      if ($urandom_range(0, 9) < 3) return 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic region_req_type req_item(input logic op, input logic [4:0] chrom,
                                               input logic [31:0] from_pos,
                                               input logic [31:0] to_pos,
                                               input logic [15:0] label,
                                               input logic [3:0] copies);
      region_req_type item;
      item.op       = op;
      item.chrom    = chrom;
      item.from_pos = from_pos;
      item.to_pos   = to_pos;
      item.label    = label;
      item.copies   = copies;
      return item;
   endfunction

   // Present one request beat after a random gap and hold it until accepted.
   task automatic send_request(input region_req_type item);
      int gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_operation      <= item.op;
      req_chrom_code     <= item.chrom;
      req_interval_begin <= item.from_pos;
      req_interval_end   <= item.to_pos;
      req_region_label   <= item.label;
      req_copies         <= item.copies;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      matcher.take_request(item);
   endtask

   // Stop sending and wait until every predicted beat has been seen.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (matcher.due_matches.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Write the cutoff register once the block has gone idle.
   task automatic set_cutoff(input logic [13:0] value);
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      matcher.cutoff = 64'(value);
   endtask

   // Result side: check each accepted beat, then stall for a random number of cycles.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_beat.matched = rsp_matched;
            seen_beat.label   = rsp_match_label;
            seen_beat.pct     = rsp_percent_hundredths;
            seen_beat.kind    = kind_type'(rsp_change_kind);
            seen_beat.last    = rsp_last;
            matcher.check_beat(seen_beat);
            rsp_wait = draw_wait();
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
      end
      rsp_stall <= (rsp_wait != 0);
   end

   // Watchdog: end the run when no beat has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top: watchdog expired with %0d beats outstanding",
                  matcher.due_matches.size());
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // Stimulus.
   initial begin
      region_req_type item;
      int phase, counted, pick;
      bit want_load;
      logic [13:0] cut;
      logic [31:0] base, len, lb, le, span;
      matcher = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at the reset cutoff: empty table, extreme fields, special cases.
      send_request(req_item(OP_QUERY, 5'd0, 32'd100, 32'd200, 16'h1111, 4'd2));
      send_request(req_item(OP_LOAD, 5'd0, 32'd100, 32'd200, 16'h0000, 4'd0));
      send_request(req_item(OP_LOAD, 5'd31, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 4'd15));
      send_request(req_item(OP_LOAD, 5'd5, 32'd1000, 32'd2000, 16'h1234, 4'd3));
      send_request(req_item(OP_LOAD, 5'd5, 32'd2000, 32'd1000, 16'h00A5, 4'd1));
      send_request(req_item(OP_LOAD, 5'd5, 32'd1500, 32'd1500, 16'h5A5A, 4'd4));
      send_request(req_item(OP_LOAD, 5'd7, 32'd500, 32'd600, 16'h0777, 4'd2));
      send_request(req_item(OP_QUERY, 5'd0, 32'd100, 32'd200, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd0, 32'd120, 32'd200, 16'hFFFF, 4'd15));
      send_request(req_item(OP_QUERY, 5'd0, 32'd150, 32'd250, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd31, 32'h0, 32'hFFFF_FFFF, 16'h0, 4'd0));
      // Reversed intervals, a zero union and a ratio above one.
      send_request(req_item(OP_QUERY, 5'd5, 32'd2000, 32'd1000, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd5, 32'd1500, 32'd1500, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd5, 32'd3000, 32'd500, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd7, 32'd550, 32'd650, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd9, 32'h0, 32'h0, 16'h0, 4'd0));

      // A zero cutoff lets any positive overlap through.
      set_cutoff(14'd0);
      send_request(req_item(OP_QUERY, 5'd0, 32'd150, 32'd250, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd7, 32'd599, 32'd700, 16'h0, 4'd0));

      // At full scale only ratios above one can match.
      set_cutoff(14'd10000);
      send_request(req_item(OP_QUERY, 5'd0, 32'd100, 32'd200, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd5, 32'd3000, 32'd500, 16'h0, 4'd0));

      // A cutoff beyond full scale is still applied exactly.
      set_cutoff(CUT_TOP);
      send_request(req_item(OP_QUERY, 5'd5, 32'd3000, 32'd500, 16'h0, 4'd0));
      send_request(req_item(OP_QUERY, 5'd5, 32'd1900, 32'd1000, 16'h0, 4'd0));

      // Random phases, each under its own cutoff. Loads cluster around a few
      // hot spots so that queries built from stored regions hit several at once.
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       cut = 14'd5000;
            2:       cut = 14'd0;
            4:       cut = 14'd10000;
            default: cut = 14'($urandom_range(500, 9500));
         endcase
         set_cutoff(cut);
         quiet_mode = (phase == 3);
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 19) == 0) wait_for_drain();
            if (matcher.loaded < TABLE_DEPTH_DEF)
               want_load = ($urandom_range(0, 99) < 45);
            else
               want_load = ($urandom_range(0, 99) < 15);
            item.label  = 16'($urandom);
            item.copies = 4'($urandom_range(0, 15));
            if (want_load) begin
               item.op = OP_LOAD;
               if ($urandom_range(0, 9) == 0) begin
                  item.chrom    = 5'($urandom_range(0, 31));
                  item.from_pos = $urandom;
                  item.to_pos   = $urandom;
               end else begin
                  item.chrom = 5'($urandom_range(1, 3));
                  base = $urandom_range(0, 3) * 32'h5555_5000 + 32'h800
                         + $urandom_range(0, 2000);
                  len = $urandom_range(1, 3000);
                  if ($urandom_range(0, 9) == 0) begin
                     item.from_pos = base + len;
                     item.to_pos   = base;
                  end else begin
                     item.from_pos = base;
                     item.to_pos   = base + len;
                  end
               end
            end else begin
               item.op = OP_QUERY;
               if (matcher.loaded == 0 || $urandom_range(0, 3) == 0) begin
                  item.chrom    = 5'($urandom_range(0, 31));
                  item.from_pos = $urandom;
                  item.to_pos   = $urandom;
               end else begin
                  // Nudge both ends of a stored region to land near the cutoff.
                  pick = $urandom_range(0, matcher.loaded - 1);
                  item.chrom = matcher.stored_chrom[pick];
                  lb = matcher.stored_begin[pick];
                  le = matcher.stored_end[pick];
                  span = ((lb > le) ? lb - le : le - lb) / 3 + 1;
                  item.from_pos = lb + $urandom_range(0, span) - $urandom_range(0, span);
                  item.to_pos   = le + $urandom_range(0, span) - $urandom_range(0, span);
               end
            end
            if (!(want_load && matcher.loaded >= TABLE_DEPTH_DEF)) counted++;
            send_request(item);
         end
      end
      quiet_mode = 1'b0;

      // Drain, then give the block time to show any stray beat.
      wait_for_drain();
      repeat (40) @(posedge clock);
      $display("tb_top: %0d regions stored, %0d loads dropped on a full table, %0d queries",
               matcher.loaded, matcher.loads_dropped, matcher.queries);
      $display("tb_top: %0d result beats checked, %0d with a match, %0d failures",
               matcher.beats_checked, matcher.hits_seen,
               matcher.errors + matcher.due_matches.size());
      if (matcher.errors == 0 && matcher.due_matches.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
